/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_PROP(label, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/ptpia_pkg.sv */
// Shared types, constants and lookup functions of the point-to-plane accumulator.
package ptpia_pkg;

    localparam int NUM_ENTRIES = 21;
    localparam int IDX_W       = 5;
    localparam int H_IDX_W     = 3;
    localparam int COORD_W     = 18;
    localparam int H_W         = 23;          // rounded cross term, Q.16
    localparam int PROD_W      = 2 * H_W;
    localparam int ROUND_SH    = 14;          // Q.30 -> Q.16
    localparam int ROUND_ADD   = 1 << (ROUND_SH - 1);
    localparam int IN_DATA_W   = 112;         // six coordinates, padded to bytes
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_USER_W  = 6;
    localparam logic [IDX_W-1:0] LAST_IDX    = 5'd20;
    localparam logic [IDX_W-1:0] CROSS_STEPS = 5'd6;
    localparam logic [IDX_W-1:0] OUTER_STEPS = 5'd21;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_CROSS,
        MUL_OUTER
    } t_mul_op;

    // Controller to datapath commands
    typedef struct packed {
        logic               load;
        t_mul_op            mul_op;
        logic [IDX_W-1:0]   mul_idx;
        logic               cross_keep;
        logic               cross_wr;
        logic [H_IDX_W-1:0] cross_idx;
        logic               acc_wr;
        logic               emit;
        logic [IDX_W-1:0]   wr_idx;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_status;

    // Row of upper-triangle entry k (row-major)
    function automatic logic [H_IDX_W-1:0] entry_row(input logic [IDX_W-1:0] k);
        logic [H_IDX_W-1:0] r;
        unique case (k) inside
            [5'd0:5'd5]:   r = 3'd0;
            [5'd6:5'd10]:  r = 3'd1;
            [5'd11:5'd14]: r = 3'd2;
            [5'd15:5'd17]: r = 3'd3;
            [5'd18:5'd19]: r = 3'd4;
            5'd20:         r = 3'd5;
            default:       r = 3'd0;
        endcase
        return r;
    endfunction

    // Column of upper-triangle entry k
    function automatic logic [H_IDX_W-1:0] entry_col(input logic [IDX_W-1:0] k);
        logic [H_IDX_W-1:0] c;
        unique case (k) inside
            [5'd0:5'd5]:   c = H_IDX_W'(k);
            [5'd6:5'd10]:  c = H_IDX_W'(k - 5'd5);
            [5'd11:5'd14]: c = H_IDX_W'(k - 5'd9);
            [5'd15:5'd17]: c = H_IDX_W'(k - 5'd12);
            [5'd18:5'd19]: c = H_IDX_W'(k - 5'd14);
            5'd20:         c = 3'd5;
            default:       c = 3'd0;
        endcase
        return c;
    endfunction

    // Point component of cross product step j (pairs give minuend, subtrahend)
    function automatic logic [1:0] cross_pt_sel(input logic [2:0] j);
        logic [1:0] s;
        unique case (j)
            3'd0:    s = 2'd1;
            3'd1:    s = 2'd2;
            3'd2:    s = 2'd2;
            3'd3:    s = 2'd0;
            3'd4:    s = 2'd0;
            3'd5:    s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    // Normal component of cross product step j
    function automatic logic [1:0] cross_nm_sel(input logic [2:0] j);
        logic [1:0] s;
        unique case (j)
            3'd0:    s = 2'd2;
            3'd1:    s = 2'd1;
            3'd2:    s = 2'd0;
            3'd3:    s = 2'd2;
            3'd4:    s = 2'd1;
            3'd5:    s = 2'd0;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/ptpia_ctrl.sv */
// Sequencer: steps the shared multiplier through cross and outer product, then readout.
module ptpia_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_in_usable,
    input  logic               i_in_last,
    input  ptpia_pkg::t_status i_status,
    output ptpia_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CROSS,
        S_OUTER,
        S_EMIT
    } t_state;

    t_state                      r_state, n_state;
    logic [ptpia_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic                        r_last, n_last;
    logic                        in_ready;
    ptpia_pkg::t_cmd             cmd;

    // Next state and command decode
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_last          = r_last;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.mul_op      = ptpia_pkg::MUL_NONE;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_last = i_in_last;
                    n_cnt  = '0;
                    if (i_in_usable) begin
                        n_state = S_CROSS;
                    end else if (i_in_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CROSS: begin
                // products issue on steps 0..5, pairs combine on steps 2, 4 and 6
                if (r_cnt < ptpia_pkg::CROSS_STEPS) begin
                    cmd.mul_op  = ptpia_pkg::MUL_CROSS;
                    cmd.mul_idx = r_cnt;
                end
                cmd.cross_keep = r_cnt[0];
                if (r_cnt != '0 && !r_cnt[0]) begin
                    cmd.cross_wr  = 1'b1;
                    cmd.cross_idx = ptpia_pkg::H_IDX_W'((r_cnt >> 1) - 5'd1);
                end
                if (r_cnt == ptpia_pkg::CROSS_STEPS) begin
                    n_state = S_OUTER;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_OUTER: begin
                // product of entry k issues at step k, accumulates at step k+1
                if (r_cnt < ptpia_pkg::OUTER_STEPS) begin
                    cmd.mul_op  = ptpia_pkg::MUL_OUTER;
                    cmd.mul_idx = r_cnt;
                end
                if (r_cnt != '0) begin
                    cmd.acc_wr = 1'b1;
                    cmd.wr_idx = r_cnt - 5'd1;
                end
                if (r_cnt == ptpia_pkg::OUTER_STEPS) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.wr_idx = r_cnt;
                    if (r_cnt == ptpia_pkg::LAST_IDX) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;

endmodule

/* rtl/ptpia_dp.sv */
// Datapath: shared multiplier, rounding, saturating accumulators and output register.
module ptpia_dp #(
    parameter int ACC_WIDTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ptpia_pkg::t_cmd                        i_cmd,
    output ptpia_pkg::t_status                     o_status,
    input  logic [ptpia_pkg::IN_DATA_W-1:0]        i_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [ptpia_pkg::H_IDX_W-1:0]          o_row,
    output logic [ptpia_pkg::H_IDX_W-1:0]          o_col,
    output logic signed [ptpia_pkg::OUT_DATA_W-1:0] o_value,
    output logic                                   o_last
);

    localparam int SUM_W  = ACC_WIDTH + 1;
    localparam int DIFF_W = ptpia_pkg::PROD_W + 1;

    logic signed [ptpia_pkg::COORD_W-1:0] r_pt [3];
    logic signed [ptpia_pkg::H_W-1:0]     r_h  [6];
    logic signed [ptpia_pkg::PROD_W-1:0]  r_prod, r_prod_a;
    logic signed [ACC_WIDTH-1:0]          r_acc [ptpia_pkg::NUM_ENTRIES];

    logic                                 r_out_valid;
    logic [ptpia_pkg::H_IDX_W-1:0]        r_out_row, r_out_col;
    logic signed [ptpia_pkg::OUT_DATA_W-1:0] r_out_value;
    logic                                 r_out_last;

    logic signed [ptpia_pkg::H_W-1:0]     mul_a, mul_b;
    logic [2:0]                           step;
    logic signed [DIFF_W-1:0]             diff, rounded;
    logic signed [ACC_WIDTH-1:0]          acc_cur, acc_sat;
    logic signed [SUM_W-1:0]              sum;

    assign step = 3'(i_cmd.mul_idx);

    // Operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_op)
            ptpia_pkg::MUL_CROSS: begin
                mul_a = ptpia_pkg::H_W'(r_pt[ptpia_pkg::cross_pt_sel(step)]);
                mul_b = ptpia_pkg::H_W'(r_h[3'd3 + 3'(ptpia_pkg::cross_nm_sel(step))]);
            end
            ptpia_pkg::MUL_OUTER: begin
                mul_a = r_h[ptpia_pkg::entry_row(i_cmd.mul_idx)];
                mul_b = r_h[ptpia_pkg::entry_col(i_cmd.mul_idx)];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Cross component: difference of two Q.30 products, round half up to Q.16
    assign diff    = DIFF_W'(r_prod_a) - DIFF_W'(r_prod) + DIFF_W'(ptpia_pkg::ROUND_ADD);
    assign rounded = diff >>> ptpia_pkg::ROUND_SH;

    // Saturating accumulate
    assign acc_cur = r_acc[i_cmd.wr_idx];
    assign sum     = SUM_W'(acc_cur) + SUM_W'(r_prod);
    always_comb begin
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
            acc_sat = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_sat = sum[ACC_WIDTH-1:0];
        end
    end

    // Input word, multiplier and row registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= i_data[17:0];
            r_pt[1] <= i_data[35:18];
            r_pt[2] <= i_data[53:36];
            r_h[3]  <= ptpia_pkg::H_W'($signed(i_data[71:54]));
            r_h[4]  <= ptpia_pkg::H_W'($signed(i_data[89:72]));
            r_h[5]  <= ptpia_pkg::H_W'($signed(i_data[107:90]));
        end
        if (i_cmd.mul_op != ptpia_pkg::MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.cross_keep) begin
            r_prod_a <= r_prod;
        end
        if (i_cmd.cross_wr) begin
            r_h[i_cmd.cross_idx] <= ptpia_pkg::H_W'(rounded);
        end
    end

    // Accumulators: zero on reset, cleared as each entry is read out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ptpia_pkg::NUM_ENTRIES; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_cmd.acc_wr) begin
            r_acc[i_cmd.wr_idx] <= acc_sat;
        end else if (i_cmd.emit) begin
            r_acc[i_cmd.wr_idx] <= '0;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= ptpia_pkg::entry_row(i_cmd.wr_idx);
            r_out_col   <= ptpia_pkg::entry_col(i_cmd.wr_idx);
            r_out_value <= ptpia_pkg::OUT_DATA_W'(acc_cur);
            r_out_last  <= (i_cmd.wr_idx == ptpia_pkg::LAST_IDX);
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_row             = r_out_row;
    assign o_col             = r_out_col;
    assign o_value           = r_out_value;
    assign o_last            = r_out_last;

endmodule

/* rtl/point_to_plane_info_accumulator.sv */
// Point-to-plane information accumulator: top level with stream ports.
// One 23x23 multiplier serves all 27 products. Usable point: cross and outer product
// run after accept, before ready again. Unusable point that is not last: ready next cycle.
// Last point: then 21 entries leave at one word per cycle unless the sink stalls.
// Reset (synchronous, active low) clears the 21 accumulators and the control at once.
`include "assert_macros.svh"

module point_to_plane_info_accumulator #(
    parameter int ACC_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point x, y, z, then matched surface normal x, y, z (18b each), 4b pad
    input  logic [ptpia_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // usable
    input  logic                                s_axis_tuser,
    // last_point
    input  logic                                s_axis_tlast,
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // entry_value
    output logic [ptpia_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // entry_row [2:0], entry_col [5:3]
    output logic [ptpia_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    // last_entry
    output logic                                m_axis_tlast
);

    ptpia_pkg::t_cmd                      w_cmd;
    ptpia_pkg::t_status                   w_status;
    logic [ptpia_pkg::H_IDX_W-1:0]        w_row, w_col;
    logic signed [ptpia_pkg::OUT_DATA_W-1:0] w_value;

    ptpia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_usable (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ptpia_dp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_data   (s_axis_tdata),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_row    (w_row),
        .o_col    (w_col),
        .o_value  (w_value),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = w_value;
    assign m_axis_tuser = {w_col, w_row};

    // No new point while the accumulators are being updated
    `ASSERT_NEVER(a_no_accept_in_acc, i_clk, i_rst_n, w_cmd.acc_wr && s_axis_tready)
    // Readout and accumulation never share the accumulator write port
    `ASSERT_NEVER(a_one_acc_write, i_clk, i_rst_n, w_cmd.acc_wr && w_cmd.emit)
    // The final entry of a readout is always the bottom-right corner
    `ASSERT_PROP(a_last_corner, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 6'h2d))
    // Entries come from the upper triangle only
    `ASSERT_PROP(a_upper_tri, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser[5:3] >= m_axis_tuser[2:0]))

endmodule
